>>> rtl/core/bemf_pkg.sv
// ----------------------------------------------------------------------------
// bemf_pkg
// Shared types and constants for the back EMF motor current limiter.
// ----------------------------------------------------------------------------
package bemf_pkg;

   localparam int CMD_W    = 8;
   localparam int MAG_W    = 7;
   localparam int DEN_W    = 8;
   localparam int NUM_W    = 14;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W    = 4;

   localparam logic [MAG_W-1:0] FULL_SCALE = 7'd127;
   localparam logic [MAG_W-1:0] EMF_CAP    = 7'd126;
   localparam logic [7:0]       LOW_GEAR_K  = 8'd243;
   localparam logic [4:0]       HIGH_GEAR_K = 5'd17;

   localparam logic CSR_DRIVE_MODE    = 1'b0;
   localparam logic CSR_CURRENT_LIMIT = 1'b1;

   localparam logic MODE_VOLTAGE = 1'b0;
   localparam logic MODE_TORQUE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMF,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

>>> rtl/core/bemf_div.sv
// ----------------------------------------------------------------------------
// bemf_div
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module bemf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bemf_pkg::div_req_type req,
   output bemf_pkg::div_rsp_type rsp
);
   import bemf_pkg::*;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.numer;
         den_in  = req.denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

endmodule

>>> rtl/core/back_emf_motor_current_limiter.sv
// ----------------------------------------------------------------------------
// back_emf_motor_current_limiter
// Estimates back EMF from velocity and limits the PWM drive to a current limit.
// ----------------------------------------------------------------------------
// steps: the input transfer is taken in ST_IDLE, the back EMF estimate is registered in ST_EMF,
// the limit test is registered and the divider started in ST_PREP, the divider runs in ST_DIV and
// ST_DONE loads the output register once it is free; a new transfer is taken only back in ST_IDLE
// a finished result waits in the output register while the next item is taken
// reset: drive_mode 0, current_limit 64, sticky limited flag cleared
// ----------------------------------------------------------------------------
module back_emf_motor_current_limiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // command[7:0], velocity[15:8]
   input  logic [0:0]  req_tuser,  // low_gear[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // pwm_out[7:0], emf_estimate[15:8]
   output logic [1:0]  rsp_tuser,  // limited_now[0], limited_ever[1]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import bemf_pkg::*;

   state_type state_ff, state_in;

   logic             mode_ff;
   logic [MAG_W-1:0] limit_ff;
   logic             sticky_ff, sticky_in;

   logic [CMD_W-1:0] cmd_ff;
   logic [CMD_W-1:0] vel_ff;
   logic             gear_ff;

   logic [MAG_W-1:0] emf_mag_ff, emf_mag_in;
   logic             emf_neg_ff, emf_neg_in;
   logic [MAG_W-1:0] cmd_mag_ff, cmd_mag_in;
   logic             cmd_neg_ff, cmd_neg_in;
   logic             cmd_zero_ff, cmd_zero_in;
   logic             over_ff, over_in;

   logic             out_valid_ff, out_valid_in;
   logic [15:0]      out_data_ff, out_data_in;
   logic [1:0]       out_user_ff, out_user_in;

   logic             accept;
   logic             load_out;
   logic             capture_emf;
   logic             capture_prep;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   bemf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EMF;
         ST_EMF:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (div_rsp.done) state_in = ST_DONE;
         ST_DONE: if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready   = 1'b0;
      capture_emf  = 1'b0;
      capture_prep = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready   = 1'b1;
         ST_EMF:  capture_emf  = 1'b1;
         ST_PREP: capture_prep = 1'b1;
         ST_DIV:  ;
         ST_DONE: load_out     = !out_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // back emf estimate and command magnitude
   logic [CMD_W-1:0] vel_abs;
   logic [CMD_W-1:0] cmd_abs;
   logic [14:0]      low_prod;
   logic [11:0]      high_prod;
   logic [10:0]      raw_emf;

   always_comb begin
      vel_abs   = vel_ff[CMD_W-1] ? (~vel_ff + 1'b1) : vel_ff;
      if (vel_ff == 8'h80) vel_abs = {1'b0, FULL_SCALE};
      cmd_abs   = cmd_ff[CMD_W-1] ? (~cmd_ff + 1'b1) : cmd_ff;
      if (cmd_ff == 8'h80) cmd_abs = {1'b0, FULL_SCALE};
      low_prod  = 15'(vel_abs[MAG_W-1:0]) * 15'(LOW_GEAR_K);
      high_prod = 12'(vel_abs[MAG_W-1:0]) * 12'(HIGH_GEAR_K);
      raw_emf   = gear_ff ? low_prod[14:4] : {1'b0, high_prod[11:2]};
      emf_mag_in  = (raw_emf > 11'(EMF_CAP)) ? EMF_CAP : raw_emf[MAG_W-1:0];
      emf_neg_in  = vel_ff[CMD_W-1];
      cmd_mag_in  = cmd_abs[MAG_W-1:0];
      cmd_neg_in  = cmd_ff[CMD_W-1];
      cmd_zero_in = (cmd_ff == '0);
   end

   // divisor, voltage-mode limit test and numerator
   logic [DEN_W-1:0] denom;
   logic [14:0]      drop_prod;
   logic [14:0]      thresh;
   logic [MAG_W-1:0] scale;

   always_comb begin
      denom     = (emf_neg_ff ^ cmd_neg_ff) ? ({1'b0, FULL_SCALE} + {1'b0, emf_mag_ff})
                                            : ({1'b0, FULL_SCALE} - {1'b0, emf_mag_ff});
      drop_prod = 15'(cmd_mag_ff) * 15'(denom);
      thresh    = (15'(limit_ff) + 15'd1) * 15'(FULL_SCALE);
      over_in   = drop_prod >= thresh;
      scale     = (mode_ff == MODE_TORQUE) ? cmd_mag_ff : FULL_SCALE;
      div_req.start = capture_prep;
      div_req.numer = NUM_W'(limit_ff) * NUM_W'(scale);
      div_req.denom = denom;
   end

   // result assembly
   logic             sat;
   logic [MAG_W-1:0] quot_sat;
   logic [MAG_W-1:0] res_mag;
   logic             lim;
   logic [CMD_W-1:0] pwm;
   logic [CMD_W-1:0] emf_out;

   always_comb begin
      sat      = div_rsp.quot > NUM_W'(FULL_SCALE);
      quot_sat = sat ? FULL_SCALE : div_rsp.quot[MAG_W-1:0];
      if (mode_ff == MODE_TORQUE) begin
         res_mag = quot_sat;
         lim     = sat;
      end else begin
         res_mag = over_ff ? quot_sat : cmd_mag_ff;
         lim     = over_ff;
      end
      if (cmd_zero_ff) begin
         res_mag = '0;
         lim     = 1'b0;
      end
      pwm     = cmd_neg_ff ? (~{1'b0, res_mag} + 1'b1) : {1'b0, res_mag};
      emf_out = emf_neg_ff ? (~{1'b0, emf_mag_ff} + 1'b1) : {1'b0, emf_mag_ff};

      sticky_in    = sticky_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      if (rsp_tvalid && rsp_tready) out_valid_in = 1'b0;
      if (load_out) begin
         sticky_in    = sticky_ff | lim;
         out_valid_in = 1'b1;
         out_data_in  = {emf_out, pwm};
         out_user_in  = {sticky_ff | lim, lim};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tdata[7:0];
         vel_ff  <= req_tdata[15:8];
         gear_ff <= req_tuser[0];
      end
      if (capture_emf) begin
         emf_mag_ff  <= emf_mag_in;
         emf_neg_ff  <= emf_neg_in;
         cmd_mag_ff  <= cmd_mag_in;
         cmd_neg_ff  <= cmd_neg_in;
         cmd_zero_ff <= cmd_zero_in;
      end
      if (capture_prep) over_ff <= over_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_VOLTAGE;
         limit_ff     <= 7'd64;
         sticky_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sticky_ff    <= sticky_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            case (csr_index[0])
               CSR_DRIVE_MODE:    mode_ff  <= csr_wdata[0];
               CSR_CURRENT_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

>>> tb/back_emf_motor_current_limiter_test.sv
// ----------------------------------------------------------------------------
// back_emf_motor_current_limiter_test
// Drives signed command, velocity and gear transfers into the limiter. Each
// accepted transfer is run through a local model of the back EMF estimate,
// the voltage and torque limiting and the sticky limited flag. The response
// stream is checked in order against it, across both drive modes, several
// current limits including 0 and 127, and several idle and stall patterns.
// ----------------------------------------------------------------------------
module back_emf_motor_current_limiter_test;
   import bemf_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_SPAN   = 400;
   localparam int SETTLE      = 30;

   typedef struct {
      logic signed [7:0] command;
      logic signed [7:0] velocity;
      logic              low_gear;
      logic              barrier;
   } drive_cmd_type;

   typedef struct {
      logic [7:0] pwm_out;
      logic [7:0] emf_estimate;
      logic       limited_now;
      logic       limited_ever;
   } drive_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // command[7:0], velocity[15:8]
   logic [0:0]  req_tuser = '0;  // low_gear[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // pwm_out[7:0], emf_estimate[15:8]
   logic [1:0]  rsp_tuser;       // limited_now[0], limited_ever[1]
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   drive_cmd_type    cmd_backlog[$];
   drive_result_type pwm_expect_q[$];
   drive_cmd_type    cmd_in_flight;

   logic       drive_mode_cfg = MODE_VOLTAGE;
   logic [6:0] current_limit_cfg = 7'd64;
   logic       limited_sticky = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_epoch = 0;
   int hold_seen;
   int hold_left;
   int errors = 0;
   int cycles = 0;

   back_emf_motor_current_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // back EMF estimate and limited drive for one command, updates sticky flag
   function automatic drive_result_type limit_drive(input drive_cmd_type c);
      int               cmd;
      int               vel;
      int               vmag;
      int               emf;
      int               e;
      int               mag;
      int               d;
      int               pwm;
      logic             lim;
      drive_result_type r;
      cmd = c.command;
      vel = c.velocity;
      pwm = 0;
      lim = 1'b0;
      if (vel < -127) vel = -127;
      if (cmd < -127) cmd = -127;
      vmag = (vel < 0) ? -vel : vel;
      emf = c.low_gear ? (vmag * 243) / 16 : (vmag * 17) / 4;
      if (emf > 126) emf = 126;
      if (vel < 0) emf = -emf;
      if (cmd != 0) begin
         mag = (cmd < 0) ? -cmd : cmd;
         e = (cmd < 0) ? -emf : emf;
         d = 127 - e;
         if (drive_mode_cfg == MODE_VOLTAGE) begin
            pwm = mag;
            if ((mag * d) / 127 > int'(current_limit_cfg)) begin
               lim = 1'b1;
               pwm = (int'(current_limit_cfg) * 127) / d;
               if (pwm > 127) pwm = 127;
            end
         end else begin
            pwm = (int'(current_limit_cfg) * mag) / d;
            if (pwm > 127) begin
               pwm = 127;
               lim = 1'b1;
            end
         end
         if (cmd < 0) pwm = -pwm;
      end
      if (lim) limited_sticky = 1'b1;
      r.pwm_out = pwm[7:0];
      r.emf_estimate = emf[7:0];
      r.limited_now = lim;
      r.limited_ever = limited_sticky;
      return r;
   endfunction

   // command driver
   always @(posedge clock) begin
      drive_cmd_type nxt;
      logic          offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) pwm_expect_q.push_back(limit_drive(cmd_in_flight));
         offer = 1'b0;
         if (cmd_backlog.size() > 0 && cmd_backlog[0].barrier) begin
            if (pwm_expect_q.size() == 0) void'(cmd_backlog.pop_front());
         end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = cmd_backlog.pop_front();
            offer = 1'b1;
            cmd_in_flight <= nxt;
            req_tdata <= {nxt.velocity, nxt.command};
            req_tuser <= nxt.low_gear;
         end
         req_tvalid <= offer;
      end
   end

   // response ready, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_epoch) begin
         hold_seen <= hold_epoch;
         hold_left <= HOLD_SPAN;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pwm_expect_q.size() == 0) begin
            $error("unexpected response transfer pwm_out %0d", $signed(rsp_tdata[7:0]));
            errors = errors + 1;
         end else begin
            want = pwm_expect_q.pop_front();
            if (rsp_tdata[7:0] !== want.pwm_out) begin
               $error("pwm_out expected %0d got %0d",
                      $signed(want.pwm_out), $signed(rsp_tdata[7:0]));
               errors = errors + 1;
            end
            if (rsp_tdata[15:8] !== want.emf_estimate) begin
               $error("emf_estimate expected %0d got %0d",
                      $signed(want.emf_estimate), $signed(rsp_tdata[15:8]));
               errors = errors + 1;
            end
            if (rsp_tuser[0] !== want.limited_now) begin
               $error("limited_now expected %0b got %0b", want.limited_now, rsp_tuser[0]);
               errors = errors + 1;
            end
            if (rsp_tuser[1] !== want.limited_ever) begin
               $error("limited_ever expected %0b got %0b", want.limited_ever, rsp_tuser[1]);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("back_emf_motor_current_limiter: mismatch");
         $finish;
      end
   end

   task automatic queue_cmd(input logic [7:0] cmd, input logic [7:0] vel, input logic gear);
      drive_cmd_type c;
      c.command = cmd;
      c.velocity = vel;
      c.low_gear = gear;
      c.barrier = 1'b0;
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_barrier();
      drive_cmd_type c;
      c.command = '0;
      c.velocity = '0;
      c.low_gear = 1'b0;
      c.barrier = 1'b1;
      cmd_backlog.push_back(c);
   endtask

   task automatic wait_idle();
      while (cmd_backlog.size() > 0 || req_tvalid || pwm_expect_q.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DRIVE_MODE) drive_mode_cfg = val[0];
      else current_limit_cfg = val;
   endtask

   initial begin
      logic mode;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // voltage mode at reset limit: extremes, clamped inputs, zero command
      queue_cmd(8'sd127, 8'sd0, 1'b0);
      queue_cmd(-8'sd127, 8'sd0, 1'b1);
      queue_cmd(8'h80, 8'sd0, 1'b0);
      queue_cmd(8'sd0, 8'sd127, 1'b1);
      queue_cmd(8'sd127, 8'sd127, 1'b1);
      queue_cmd(8'sd127, 8'h80, 1'b1);
      queue_cmd(-8'sd127, 8'sd127, 1'b0);
      queue_cmd(-8'sd127, 8'h80, 1'b0);
      queue_cmd(8'sd1, -8'sd1, 1'b1);
      queue_cmd(-8'sd1, 8'sd1, 1'b0);
      queue_cmd(8'sd127, -8'sd1, 1'b0);
      queue_cmd(8'sd0, 8'h80, 1'b0);
      wait_idle();

      // torque mode at full limit: saturation both signs
      write_csr(CSR_DRIVE_MODE, {6'h2a, MODE_TORQUE});
      write_csr(CSR_CURRENT_LIMIT, 7'd127);
      queue_cmd(8'sd127, 8'sd127, 1'b1);
      queue_cmd(8'sd127, 8'h80, 1'b1);
      queue_cmd(-8'sd127, 8'h80, 1'b1);
      queue_cmd(8'h80, 8'sd127, 1'b0);
      queue_cmd(8'sd1, 8'sd0, 1'b0);
      queue_cmd(8'sd0, 8'sd0, 1'b1);
      wait_idle();

      // voltage mode with zero limit
      write_csr(CSR_DRIVE_MODE, {6'h15, MODE_VOLTAGE});
      write_csr(CSR_CURRENT_LIMIT, 7'd0);
      queue_cmd(8'sd127, 8'sd0, 1'b1);
      queue_cmd(-8'sd1, 8'sd0, 1'b0);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         mode = 1'(((p >> 2) ^ p) & 1);
         write_csr(CSR_DRIVE_MODE, {6'($urandom_range(63)), mode});
         if (p == 0) write_csr(CSR_CURRENT_LIMIT, 7'd0);
         else if (p == 1) write_csr(CSR_CURRENT_LIMIT, 7'd127);
         else write_csr(CSR_CURRENT_LIMIT, 7'($urandom_range(127)));
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 81;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 81;
            end
            default: begin
               send_idle_pct = 32;
               recv_stall_pct = 32;
            end
         endcase
         if (p == 0) hold_epoch = hold_epoch + 1;
         for (int i = 0; i < 131; i++) begin
            if (p == 3 && i == 65) queue_barrier();
            queue_cmd(8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
         end
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pwm_expect_q.size() == 0) begin
         $display("back_emf_motor_current_limiter: match");
      end else begin
         $display("back_emf_motor_current_limiter: mismatch");
      end
      $finish;
   end

endmodule
